@@ src/windowed_waveform_statistics_macros.svh @@
// assertion helpers for the block's modules, included by wws_back
`ifndef WINDOWED_WAVEFORM_STATISTICS_MACROS_SVH
`define WINDOWED_WAVEFORM_STATISTICS_MACROS_SVH

// same-cycle implication, clocked on clock, off during reset
`define WWS_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("wws assertion failed");

// next-cycle implication, clocked on clock, off during reset
`define WWS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("wws assertion failed");

`endif

@@ src/wws_pkg.sv @@
`default_nettype none

package wws_pkg;

   localparam int unsigned TIME_W     = 24;
   localparam int unsigned VALUE_W    = 16;
   localparam int unsigned AREA_W     = VALUE_W + TIME_W + 2;
   localparam int unsigned SQ_W       = 2 * VALUE_W + TIME_W + 1;
   localparam int unsigned OUT_W      = 48;
   localparam int unsigned MODE_W     = 3;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 24;
   localparam int unsigned SUM_W      = VALUE_W + 1;
   localparam int unsigned SQSUM_W    = 2 * VALUE_W;
   localparam int unsigned PSQ_W      = SQSUM_W + TIME_W;
   localparam int unsigned DIVISOR_W  = TIME_W + 1;
   localparam int unsigned ROOT_W     = (SQ_W + 1) / 2;
   localparam int unsigned STEP_CNT_W = $clog2(SQ_W);
   localparam int unsigned FIFO_DEPTH = 4;
   localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);

   typedef logic [MODE_W-1:0] mode_type;

   localparam mode_type MODE_MIN   = 3'd0;
   localparam mode_type MODE_MAX   = 3'd1;
   localparam mode_type MODE_P2P   = 3'd2;
   localparam mode_type MODE_AVG   = 3'd3;
   localparam mode_type MODE_RMS   = 3'd4;
   localparam mode_type MODE_INTEG = 3'd5;

   localparam logic [CSR_IDX_W-1:0] CSR_MODE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WSTART = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WEND   = 2'd2;

   typedef struct packed {
      logic [TIME_W-1:0]         stime;
      logic signed [VALUE_W-1:0] value;
      logic                      in_window;
      logic                      last;
   } sample_type;

   typedef enum logic [2:0] {
      ST_RUN,
      ST_PREP,
      ST_DIV,
      ST_SQRT,
      ST_OUT
   } fin_state_type;

endpackage

`default_nettype wire

@@ src/wws_front.sv @@
`default_nettype none

module wws_front (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic [wws_pkg::TIME_W-1:0]            req_sample_time,
   input  wire logic signed [wws_pkg::VALUE_W-1:0]    req_sample_value,
   input  wire logic                                  req_last_sample,
   input  wire logic                                  csr_write,
   input  wire logic [wws_pkg::CSR_IDX_W-1:0]         csr_index,
   input  wire logic [wws_pkg::CSR_DATA_W-1:0]        csr_data,
   input  wire logic                                  queue_full,
   output logic                                       queue_push,
   output wws_pkg::sample_type                        queue_entry,
   output wws_pkg::mode_type                          mode
);

   wws_pkg::mode_type               mode_ff, mode_in;
   logic [wws_pkg::TIME_W-1:0]      wstart_ff, wstart_in;
   logic [wws_pkg::TIME_W-1:0]      wend_ff, wend_in;

   always_comb begin
      mode_in   = mode_ff;
      wstart_in = wstart_ff;
      wend_in   = wend_ff;
      if (csr_write) begin
         case (csr_index)
            wws_pkg::CSR_MODE:   mode_in   = csr_data[wws_pkg::MODE_W-1:0];
            wws_pkg::CSR_WSTART: wstart_in = csr_data[wws_pkg::TIME_W-1:0];
            wws_pkg::CSR_WEND:   wend_in   = csr_data[wws_pkg::TIME_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= wws_pkg::MODE_MIN;
         wstart_ff <= '0;
         wend_ff   <= '1;
      end else begin
         mode_ff   <= mode_in;
         wstart_ff <= wstart_in;
         wend_ff   <= wend_in;
      end
   end

   // window test at transfer time
   always_comb begin
      req_stall             = queue_full;
      queue_push            = req_valid && !queue_full;
      queue_entry.stime     = req_sample_time;
      queue_entry.value     = req_sample_value;
      queue_entry.last      = req_last_sample;
      queue_entry.in_window = (req_sample_time >= wstart_ff) && (req_sample_time <= wend_ff);
      mode                  = mode_ff;
   end

endmodule

`default_nettype wire

@@ src/wws_queue.sv @@
`default_nettype none

module wws_queue (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           push,
   input  wire wws_pkg::sample_type push_entry,
   output logic                full,
   input  wire logic           pop,
   output wws_pkg::sample_type pop_entry,
   output logic                empty
);

   wws_pkg::sample_type                 mem_ff [wws_pkg::FIFO_DEPTH];
   logic [wws_pkg::FIFO_PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [wws_pkg::FIFO_PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [wws_pkg::FIFO_PTR_W:0]        count_ff, count_in;

   always_comb begin
      full      = (count_ff == (wws_pkg::FIFO_PTR_W+1)'(wws_pkg::FIFO_DEPTH));
      empty     = (count_ff == '0);
      pop_entry = mem_ff[rd_ptr_ff];
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

@@ src/wws_back.sv @@
`default_nettype none

module wws_back (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire wws_pkg::mode_type                 mode,
   input  wire wws_pkg::sample_type               queue_entry,
   input  wire logic                              queue_empty,
   output logic                                   queue_pop,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic signed [wws_pkg::OUT_W-1:0]       rsp_measured_value,
   output logic                                   rsp_measure_valid
);

   `include "windowed_waveform_statistics_macros.svh"

   localparam int unsigned TW = wws_pkg::TIME_W;
   localparam int unsigned VW = wws_pkg::VALUE_W;
   localparam int unsigned AW = wws_pkg::AREA_W;
   localparam int unsigned SW = wws_pkg::SQ_W;
   localparam int unsigned OW = wws_pkg::OUT_W;
   localparam int unsigned DW = wws_pkg::DIVISOR_W;
   localparam int unsigned RW = wws_pkg::ROOT_W;
   localparam int unsigned CW = wws_pkg::STEP_CNT_W;

   wws_pkg::fin_state_type state_ff, state_in;

   // record state
   logic                      seen_ff, seen_in;
   logic [TW-1:0]             first_time_ff, first_time_in;
   logic signed [VW-1:0]      first_value_ff, first_value_in;
   logic [TW-1:0]             prev_time_ff, prev_time_in;
   logic signed [VW-1:0]      prev_value_ff, prev_value_in;
   logic signed [VW-1:0]      min_ff, min_in;
   logic signed [VW-1:0]      max_ff, max_in;
   logic signed [AW-1:0]      area_ff, area_in;
   logic [SW-1:0]             sqa_ff, sqa_in;

   // interval pipeline
   logic                      a_vld_ff, a_vld_in;
   logic                      a_take_ff, a_take_in;
   logic                      a_first_ff, a_first_in;
   logic                      a_last_ff, a_last_in;
   logic [TW-1:0]             a_dt_ff, a_dt_in;
   logic signed [wws_pkg::SUM_W-1:0]   a_sum_ff, a_sum_in;
   logic [wws_pkg::SQSUM_W-1:0]        a_sq_ff, a_sq_in;
   logic                      b_vld_ff, b_vld_in;
   logic                      b_take_ff, b_take_in;
   logic                      b_first_ff, b_first_in;
   logic                      b_last_ff, b_last_in;
   logic signed [AW-1:0]      b_parea_ff, b_parea_in;
   logic [wws_pkg::PSQ_W-1:0] b_psq_ff, b_psq_in;

   // finish units
   logic                      neg_ff, neg_in;
   logic [SW-1:0]             div_q_ff, div_q_in;
   logic [DW-1:0]             div_rem_ff, div_rem_in;
   logic [DW-1:0]             div_d_ff, div_d_in;
   logic [2*RW-1:0]           sq_src_ff, sq_src_in;
   logic [RW+1:0]             sq_rem_ff, sq_rem_in;
   logic [RW-1:0]             root_ff, root_in;
   logic [CW-1:0]             cnt_ff, cnt_in;
   logic signed [OW-1:0]      res_ff, res_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [OW-1:0]      rsp_value_ff, rsp_value_in;
   logic                      rsp_mvalid_ff, rsp_mvalid_in;

   logic                      pop;
   logic signed [2*VW-1:0]    pp, vv;
   logic signed [AW:0]        area_sum;
   logic [SW:0]               sqa_sum;
   logic [TW-1:0]             span;
   logic [AW-1:0]             area_mag;
   logic signed [AW-1:0]      area_adj;
   logic signed [AW-1:0]      area_half;
   logic signed [VW:0]        first_ext;
   logic signed [VW:0]        first_abs;
   logic [DW:0]               div_trial;
   logic                      div_ge;
   logic [SW-1:0]             div_q_next;
   logic signed [AW-1:0]      quot_s;
   logic [RW+3:0]             sq_trial_rem;
   logic [RW+3:0]             sq_trial;
   logic                      sq_ge;
   logic [RW-1:0]             root_next;
   logic                      out_load;

   always_comb begin
      state_in       = state_ff;
      seen_in        = seen_ff;
      first_time_in  = first_time_ff;
      first_value_in = first_value_ff;
      prev_time_in   = prev_time_ff;
      prev_value_in  = prev_value_ff;
      min_in         = min_ff;
      max_in         = max_ff;
      area_in        = area_ff;
      sqa_in         = sqa_ff;
      neg_in         = neg_ff;
      div_q_in       = div_q_ff;
      div_rem_in     = div_rem_ff;
      div_d_in       = div_d_ff;
      sq_src_in      = sq_src_ff;
      sq_rem_in      = sq_rem_ff;
      root_in        = root_ff;
      cnt_in         = cnt_ff;
      res_in         = res_ff;
      rsp_value_in   = rsp_value_ff;
      rsp_mvalid_in  = rsp_mvalid_ff;
      out_load       = 1'b0;

      pop = (state_ff == wws_pkg::ST_RUN) && !queue_empty
            && !(a_vld_ff && a_last_ff) && !(b_vld_ff && b_last_ff);

      // stage a: interval terms against the previous sample
      pp        = prev_value_ff * prev_value_ff;
      vv        = queue_entry.value * queue_entry.value;
      a_vld_in  = pop;
      a_take_in = queue_entry.in_window;
      a_first_in = !seen_ff;
      a_last_in = queue_entry.last;
      a_dt_in   = (queue_entry.stime > prev_time_ff) ? queue_entry.stime - prev_time_ff : '0;
      a_sum_in  = {prev_value_ff[VW-1], prev_value_ff}
                  + {queue_entry.value[VW-1], queue_entry.value};
      a_sq_in   = $unsigned(pp) + $unsigned(vv);
      if (pop && queue_entry.in_window) begin
         prev_time_in  = queue_entry.stime;
         prev_value_in = queue_entry.value;
         if (!seen_ff) begin
            seen_in        = 1'b1;
            first_time_in  = queue_entry.stime;
            first_value_in = queue_entry.value;
            min_in         = queue_entry.value;
            max_in         = queue_entry.value;
         end else begin
            if (queue_entry.value < min_ff) min_in = queue_entry.value;
            if (queue_entry.value > max_ff) max_in = queue_entry.value;
         end
      end

      // stage b: products
      b_vld_in   = a_vld_ff;
      b_take_in  = a_take_ff;
      b_first_in = a_first_ff;
      b_last_in  = a_last_ff;
      b_parea_in = AW'(a_sum_ff) * $signed({{(AW-TW){1'b0}}, a_dt_ff});
      b_psq_in   = wws_pkg::PSQ_W'(a_sq_ff) * wws_pkg::PSQ_W'(a_dt_ff);

      // stage c: saturating accumulation
      area_sum = {area_ff[AW-1], area_ff} + {b_parea_ff[AW-1], b_parea_ff};
      sqa_sum  = {1'b0, sqa_ff} + (SW+1)'(b_psq_ff);
      if (b_vld_ff && b_take_ff) begin
         if (b_first_ff) begin
            area_in = '0;
            sqa_in  = '0;
         end else begin
            if (area_sum[AW] != area_sum[AW-1]) begin
               area_in = area_sum[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
            end else begin
               area_in = area_sum[AW-1:0];
            end
            sqa_in = sqa_sum[SW] ? '1 : sqa_sum[SW-1:0];
         end
      end

      // finish arithmetic
      span      = (prev_time_ff > first_time_ff) ? prev_time_ff - first_time_ff : '0;
      area_mag  = area_ff[AW-1] ? $unsigned(-area_ff) : $unsigned(area_ff);
      area_adj  = area_ff + $signed({{(AW-1){1'b0}}, area_ff[AW-1]});
      area_half = area_adj >>> 1;
      first_ext = {first_value_ff[VW-1], first_value_ff};
      first_abs = first_value_ff[VW-1] ? -first_ext : first_ext;

      div_trial  = {div_rem_ff, div_q_ff[SW-1]};
      div_ge     = div_trial >= {1'b0, div_d_ff};
      div_q_next = {div_q_ff[SW-2:0], div_ge};
      quot_s     = $signed(div_q_next[AW-1:0]);

      sq_trial_rem = {sq_rem_ff, sq_src_ff[2*RW-1 -: 2]};
      sq_trial     = {2'b00, root_ff, 2'b01};
      sq_ge        = sq_trial_rem >= sq_trial;
      root_next    = {root_ff[RW-2:0], sq_ge};

      case (state_ff)
         wws_pkg::ST_RUN: begin
            if (b_vld_ff && b_last_ff) state_in = wws_pkg::ST_PREP;
         end
         wws_pkg::ST_PREP: begin
            neg_in     = area_ff[AW-1];
            div_rem_in = '0;
            div_d_in   = {span, 1'b0};
            cnt_in     = '0;
            state_in   = wws_pkg::ST_OUT;
            res_in     = '0;
            if (seen_ff) begin
               case (mode)
                  wws_pkg::MODE_MIN: res_in = OW'(min_ff);
                  wws_pkg::MODE_MAX: res_in = OW'(max_ff);
                  wws_pkg::MODE_P2P: res_in = OW'($signed({max_ff[VW-1], max_ff}
                                                   - {min_ff[VW-1], min_ff}));
                  wws_pkg::MODE_AVG: begin
                     res_in = OW'(first_value_ff);
                     if (span != '0) begin
                        div_q_in = SW'(area_mag);
                        state_in = wws_pkg::ST_DIV;
                     end
                  end
                  wws_pkg::MODE_RMS: begin
                     res_in = OW'(first_abs);
                     if (span != '0) begin
                        div_q_in = sqa_ff;
                        state_in = wws_pkg::ST_DIV;
                     end
                  end
                  wws_pkg::MODE_INTEG: res_in = OW'(area_half);
                  default: res_in = '0;
               endcase
            end
         end
         wws_pkg::ST_DIV: begin
            div_q_in   = div_q_next;
            div_rem_in = div_ge ? DW'(div_trial - {1'b0, div_d_ff}) : DW'(div_trial);
            cnt_in     = cnt_ff + 1'b1;
            if (cnt_ff == CW'(SW - 1)) begin
               cnt_in = '0;
               if (mode == wws_pkg::MODE_RMS) begin
                  sq_src_in = (2*RW)'(div_q_next);
                  sq_rem_in = '0;
                  root_in   = '0;
                  state_in  = wws_pkg::ST_SQRT;
               end else begin
                  res_in   = neg_ff ? OW'(-quot_s) : OW'(quot_s);
                  state_in = wws_pkg::ST_OUT;
               end
            end
         end
         wws_pkg::ST_SQRT: begin
            sq_src_in = {sq_src_ff[2*RW-3:0], 2'b00};
            sq_rem_in = sq_ge ? (RW+2)'(sq_trial_rem - sq_trial) : (RW+2)'(sq_trial_rem);
            root_in   = root_next;
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == CW'(RW - 1)) begin
               res_in   = OW'(root_next);
               state_in = wws_pkg::ST_OUT;
            end
         end
         wws_pkg::ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               out_load      = 1'b1;
               rsp_value_in  = res_ff;
               rsp_mvalid_in = seen_ff;
               seen_in       = 1'b0;
               state_in      = wws_pkg::ST_RUN;
            end
         end
         default: state_in = wws_pkg::ST_RUN;
      endcase

      rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wws_pkg::ST_RUN;
         seen_ff      <= 1'b0;
         a_vld_ff     <= 1'b0;
         b_vld_ff     <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seen_ff      <= seen_in;
         a_vld_ff     <= a_vld_in;
         b_vld_ff     <= b_vld_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      first_time_ff  <= first_time_in;
      first_value_ff <= first_value_in;
      prev_time_ff   <= prev_time_in;
      prev_value_ff  <= prev_value_in;
      min_ff         <= min_in;
      max_ff         <= max_in;
      area_ff        <= area_in;
      sqa_ff         <= sqa_in;
      a_take_ff      <= a_take_in;
      a_first_ff     <= a_first_in;
      a_last_ff      <= a_last_in;
      a_dt_ff        <= a_dt_in;
      a_sum_ff       <= a_sum_in;
      a_sq_ff        <= a_sq_in;
      b_take_ff      <= b_take_in;
      b_first_ff     <= b_first_in;
      b_last_ff      <= b_last_in;
      b_parea_ff     <= b_parea_in;
      b_psq_ff       <= b_psq_in;
      neg_ff         <= neg_in;
      div_q_ff       <= div_q_in;
      div_rem_ff     <= div_rem_in;
      div_d_ff       <= div_d_in;
      sq_src_ff      <= sq_src_in;
      sq_rem_ff      <= sq_rem_in;
      root_ff        <= root_in;
      res_ff         <= res_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_mvalid_ff  <= rsp_mvalid_in;
   end

   assign queue_pop          = pop;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_measured_value = rsp_value_ff;
   assign rsp_measure_valid  = rsp_mvalid_ff;

   `WWS_ASSERT_IMPLY(a_pop_only_running, pop, state_ff == wws_pkg::ST_RUN && !(b_vld_ff && b_last_ff))
   `WWS_ASSERT_NEXT(a_no_spurious_rsp, !rsp_valid_ff && state_ff != wws_pkg::ST_OUT, !rsp_valid_ff)
   `WWS_ASSERT_NEXT(a_finish_clears, out_load, !seen_ff && rsp_valid_ff && state_ff == wws_pkg::ST_RUN)

endmodule

`default_nettype wire

@@ src/windowed_waveform_statistics.sv @@
// channel   direction  handshake              payload
// req       in         req_valid / req_stall  sample_time, sample_value, last_sample
// rsp       out        rsp_valid / rsp_stall  measured_value, measure_valid
// csr       in         csr_write              csr_index, csr_data
//
// samples enter a 4-deep queue at one per cycle while it is not full and pass a 3-stage interval pipe
// a record accumulates its samples, then finishes through the prep and output states
// average adds a pass through the shared restoring divider, rms the divider and then the sqrt
// synchronous active-high reset; the result register frees the pipe while rsp is stalled
`default_nettype none

module windowed_waveform_statistics (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic [wws_pkg::TIME_W-1:0]            req_sample_time,
   input  wire logic signed [wws_pkg::VALUE_W-1:0]    req_sample_value,
   input  wire logic                                  req_last_sample,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic signed [wws_pkg::OUT_W-1:0]           rsp_measured_value,
   output logic                                       rsp_measure_valid,
   input  wire logic                                  csr_write,
   input  wire logic [wws_pkg::CSR_IDX_W-1:0]         csr_index,
   input  wire logic [wws_pkg::CSR_DATA_W-1:0]        csr_data
);

   logic                queue_full;
   logic                queue_push;
   logic                queue_pop;
   logic                queue_empty;
   wws_pkg::sample_type push_entry;
   wws_pkg::sample_type pop_entry;
   wws_pkg::mode_type   mode;

   wws_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample_time  (req_sample_time),
      .req_sample_value (req_sample_value),
      .req_last_sample  (req_last_sample),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .queue_full       (queue_full),
      .queue_push       (queue_push),
      .queue_entry      (push_entry),
      .mode             (mode)
   );

   wws_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (queue_push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (queue_pop),
      .pop_entry  (pop_entry),
      .empty      (queue_empty)
   );

   wws_back u_back (
      .clock              (clock),
      .reset              (reset),
      .mode               (mode),
      .queue_entry        (pop_entry),
      .queue_empty        (queue_empty),
      .queue_pop          (queue_pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_measured_value (rsp_measured_value),
      .rsp_measure_valid  (rsp_measure_valid)
   );

endmodule

`default_nettype wire
